[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL in this folder.
// Both macros sample on clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define UDRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define UDRF_ASSERT_IMPL(lbl, ante, cons, msg) \
  `UDRF_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/core/udrf_pkg.sv]
package udrf_pkg;

  localparam int TX_DEPTH = 16;
  localparam int RX_DEPTH = 16;
  localparam int TX_IDX_W = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_IDX_W = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;

  typedef logic [TX_IDX_W-1:0] tx_idx_t;
  typedef logic [RX_IDX_W-1:0] rx_idx_t;
  typedef logic [7:0]          byte_t;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_TX_READY  = 2'd1,
    OP_RX_BYTE   = 2'd2,
    OP_CPU_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TX_FULL  = 3'd1,
    ST_RX_EMPTY = 3'd2,
    ST_RX_DROP  = 3'd3,
    ST_OVERRUN  = 3'd4
  } status_t;

  // Ring pointers and error counters
  typedef struct packed {
    tx_idx_t tx_head;
    tx_idx_t tx_tail;
    rx_idx_t rx_head;
    rx_idx_t rx_tail;
    byte_t   overrun_counter;
    byte_t   framing_counter;
    byte_t   drop_counter;
  } ring_state_t;

  // Store write strobes from the step logic
  typedef struct packed {
    logic tx_wr;
    logic rx_wr;
  } store_ctl_t;

  typedef struct packed {
    logic    line_valid;
    byte_t   line_byte;
    logic    read_valid;
    byte_t   read_byte;
    status_t status;
    logic    rx_available;
    logic    tx_empty;
    logic    tx_pending;
    byte_t   overrun_count;
    byte_t   framing_count;
    byte_t   drop_count;
  } result_t;

  function automatic tx_idx_t tx_next(tx_idx_t i);
    return (i == tx_idx_t'(TX_DEPTH - 1)) ? '0 : i + tx_idx_t'(1);
  endfunction

  function automatic rx_idx_t rx_next(rx_idx_t i);
    return (i == rx_idx_t'(RX_DEPTH - 1)) ? '0 : i + rx_idx_t'(1);
  endfunction

endpackage

[rtl/core/udrf_if.sv]
interface udrf_cmd_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data;
  logic       tx_holding_empty;
  logic       overrun;
  logic       framing_error;

  modport source (
    input  clk, ready,
    output valid, op, data, tx_holding_empty, overrun, framing_error
  );
  modport sink (
    input  clk, valid, op, data, tx_holding_empty, overrun, framing_error,
    output ready
  );
endinterface

interface udrf_res_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [2:0] status;
  logic       rx_available;
  logic       tx_empty;
  logic       tx_pending;
  logic [7:0] overrun_count;
  logic [7:0] framing_count;
  logic [7:0] drop_count;

  modport source (
    input  clk, ready,
    output valid, line_valid, line_byte, read_valid, read_byte, status,
           rx_available, tx_empty, tx_pending, overrun_count, framing_count,
           drop_count
  );
  modport sink (
    input  clk, valid, line_valid, line_byte, read_valid, read_byte, status,
           rx_available, tx_empty, tx_pending, overrun_count, framing_count,
           drop_count,
    output ready
  );
endinterface

[rtl/core/udrf_step.sv]
module udrf_step (
  input  udrf_pkg::op_t         op,
  input  udrf_pkg::byte_t       data,
  input  logic                  hold_free,
  input  logic                  ovr,
  input  logic                  ferr,
  input  udrf_pkg::ring_state_t state,
  input  udrf_pkg::byte_t       tx_rd_byte,
  input  udrf_pkg::byte_t       rx_rd_byte,
  output udrf_pkg::ring_state_t state_next,
  output udrf_pkg::store_ctl_t  store_ctl,
  output udrf_pkg::result_t     res
);

  logic              tx_is_empty;
  logic              rx_is_empty;
  udrf_pkg::tx_idx_t tx_head_inc;
  udrf_pkg::rx_idx_t rx_head_inc;

  assign tx_is_empty = (state.tx_head == state.tx_tail);
  assign rx_is_empty = (state.rx_head == state.rx_tail);
  assign tx_head_inc = udrf_pkg::tx_next(state.tx_head);
  assign rx_head_inc = udrf_pkg::rx_next(state.rx_head);

  // Decode one transaction into pointer, counter and store updates
  always_comb begin
    state_next = state;
    store_ctl  = '0;
    res        = '0;
    res.status = udrf_pkg::ST_OK;
    case (op)
      udrf_pkg::OP_CPU_WRITE: begin
        if (tx_is_empty && hold_free) begin
          res.line_valid = 1'b1;
          res.line_byte  = data;
        end else if (tx_head_inc == state.tx_tail) begin
          res.status = udrf_pkg::ST_TX_FULL;
        end else begin
          store_ctl.tx_wr    = 1'b1;
          state_next.tx_head = tx_head_inc;
        end
      end
      udrf_pkg::OP_TX_READY: begin
        if (!tx_is_empty) begin
          res.line_valid     = 1'b1;
          res.line_byte      = tx_rd_byte;
          state_next.tx_tail = udrf_pkg::tx_next(state.tx_tail);
        end
      end
      udrf_pkg::OP_RX_BYTE: begin
        if (ovr) begin
          state_next.overrun_counter = state.overrun_counter + 8'd1;
          res.status = udrf_pkg::ST_OVERRUN;
        end else begin
          if (ferr) begin
            state_next.framing_counter = state.framing_counter + 8'd1;
          end
          if (rx_head_inc != state.rx_tail) begin
            store_ctl.rx_wr    = 1'b1;
            state_next.rx_head = rx_head_inc;
          end else begin
            state_next.drop_counter = state.drop_counter + 8'd1;
            res.status = udrf_pkg::ST_RX_DROP;
          end
        end
      end
      udrf_pkg::OP_CPU_READ: begin
        if (rx_is_empty) begin
          res.status = udrf_pkg::ST_RX_EMPTY;
        end else begin
          res.read_valid     = 1'b1;
          res.read_byte      = rx_rd_byte;
          state_next.rx_tail = udrf_pkg::rx_next(state.rx_tail);
        end
      end
      default: begin
      end
    endcase

    // Flags and counters reflect the state after the transaction
    res.rx_available  = (state_next.rx_head != state_next.rx_tail);
    res.tx_empty      = (state_next.tx_head == state_next.tx_tail);
    res.tx_pending    = (state_next.tx_head != state_next.tx_tail);
    res.overrun_count = state_next.overrun_counter;
    res.framing_count = state_next.framing_counter;
    res.drop_count    = state_next.drop_counter;
  end

endmodule

[rtl/core/uart_dual_ring_fifo_top.sv]
// A transaction waits in the input register, is decoded by the step logic and is loaded into the result register.
// Throughput: one transaction per cycle while the result register is free; a stalled result holds the input register.
// Each ring holds up to depth minus one bytes; a full ring and a read of an empty receive ring are reported by status.
// Reset (rst, synchronous, active high) clears ring pointers, error counters and valids.
// Ring contents are not cleared; an entry is only read after it has been written.
`include "assert_macros.svh"

module uart_dual_ring_fifo_top (
  input logic               clk,
  input logic               rst,
  udrf_cmd_if.sink          cmd,
  udrf_res_if.source        res
);

  logic                  in_valid;
  udrf_pkg::op_t         in_op;
  udrf_pkg::byte_t       in_data;
  logic                  in_hold_free;
  logic                  in_ovr;
  logic                  in_ferr;

  logic                  res_valid;
  udrf_pkg::result_t     res_q;

  udrf_pkg::ring_state_t state;
  udrf_pkg::ring_state_t state_next;
  udrf_pkg::store_ctl_t  store_ctl;
  udrf_pkg::result_t     step_res;

  udrf_pkg::byte_t       tx_store [udrf_pkg::TX_DEPTH];
  udrf_pkg::byte_t       rx_store [udrf_pkg::RX_DEPTH];

  logic                  advance;
  logic                  take;

  // Move the held transaction forward when the result register is free
  assign advance   = in_valid && (!res_valid || res.ready);
  assign cmd.ready = !in_valid || advance;
  assign take      = cmd.valid && cmd.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op        <= udrf_pkg::op_t'(cmd.op);
      in_data      <= cmd.data;
      in_hold_free <= cmd.tx_holding_empty;
      in_ovr       <= cmd.overrun;
      in_ferr      <= cmd.framing_error;
    end
  end

  udrf_step u_step (
    .op         (in_op),
    .data       (in_data),
    .hold_free  (in_hold_free),
    .ovr        (in_ovr),
    .ferr       (in_ferr),
    .state      (state),
    .tx_rd_byte (tx_store[state.tx_tail]),
    .rx_rd_byte (rx_store[state.rx_tail]),
    .state_next (state_next),
    .store_ctl  (store_ctl),
    .res        (step_res)
  );

  // Pointers and counters advance with each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Ring storage writes at the head pointer
  always_ff @(posedge clk) begin
    if (advance && store_ctl.tx_wr) begin
      tx_store[state.tx_head] <= in_data;
    end
    if (advance && store_ctl.rx_wr) begin
      rx_store[state.rx_head] <= in_data;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign res.valid         = res_valid;
  assign res.line_valid    = res_q.line_valid;
  assign res.line_byte     = res_q.line_byte;
  assign res.read_valid    = res_q.read_valid;
  assign res.read_byte     = res_q.read_byte;
  assign res.status        = res_q.status;
  assign res.rx_available  = res_q.rx_available;
  assign res.tx_empty      = res_q.tx_empty;
  assign res.tx_pending    = res_q.tx_pending;
  assign res.overrun_count = res_q.overrun_count;
  assign res.framing_count = res_q.framing_count;
  assign res.drop_count    = res_q.drop_count;

  `UDRF_ASSERT_IMPL(a_pending_flag, res_valid, res_q.tx_pending != res_q.tx_empty, "tx_pending must mirror tx_empty")
  `UDRF_ASSERT_IMPL(a_tx_no_overfill, advance && store_ctl.tx_wr, udrf_pkg::tx_next(state.tx_head) != state.tx_tail, "transmit ring overfilled")
  `UDRF_ASSERT_IMPL(a_rx_pop_nonempty, advance && step_res.read_valid, state.rx_head != state.rx_tail, "read from empty receive ring")
  `UDRF_ASSERT(a_state_hold, !advance |=> $stable(state), "ring state changed without a transaction")

endmodule

[tb/tb_uart_dual_ring_fifo_top.sv]
module tb_uart_dual_ring_fifo_top;

  localparam int NO_PROGRESS_LIMIT = 2000;
  localparam int SETTLE_CYCLES     = 4;
  localparam int PRINT_LIMIT       = 50;

  typedef struct packed {
    udrf_pkg::op_t   op;
    udrf_pkg::byte_t data;
    logic            hold_free;
    logic            ovr;
    logic            ferr;
  } uart_cmd_t;

  typedef enum int {FILL_TX, DRAIN_TX, FILL_RX, DRAIN_RX, NOISE} burst_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  udrf_cmd_if cmd_if (.clk(clk));
  udrf_res_if res_if (.clk(clk));

  uart_dual_ring_fifo_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #4 clk = ~clk;

  uart_cmd_t          pending_cmds[$];
  udrf_pkg::result_t  expected_results[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          op_count[4]    = '{0, 0, 0, 0};
  int          tx_full_seen   = 0;
  int          rx_drop_seen   = 0;

  // Shadow copy of both rings and the error counters
  udrf_pkg::byte_t tx_ring[udrf_pkg::TX_DEPTH];
  udrf_pkg::byte_t rx_ring[udrf_pkg::RX_DEPTH];
  int              tx_wr_ptr = 0;
  int              tx_rd_ptr = 0;
  int              rx_wr_ptr = 0;
  int              rx_rd_ptr = 0;
  udrf_pkg::byte_t overruns  = '0;
  udrf_pkg::byte_t framings  = '0;
  udrf_pkg::byte_t drops     = '0;

  function automatic int ring_inc(int i, int depth);
    return (i + 1 == depth) ? 0 : i + 1;
  endfunction

  // Advance the shadow rings by one command and return the result it produces
  function automatic udrf_pkg::result_t step_rings(uart_cmd_t c);
    udrf_pkg::result_t r;
    int                nxt;
    r = '0;
    r.status = udrf_pkg::ST_OK;
    case (c.op)
      udrf_pkg::OP_CPU_WRITE: begin
        if (tx_wr_ptr == tx_rd_ptr && c.hold_free) begin
          r.line_valid = 1'b1;
          r.line_byte  = c.data;
        end else begin
          nxt = ring_inc(tx_wr_ptr, udrf_pkg::TX_DEPTH);
          if (nxt == tx_rd_ptr) begin
            r.status = udrf_pkg::ST_TX_FULL;
          end else begin
            tx_ring[tx_wr_ptr] = c.data;
            tx_wr_ptr = nxt;
          end
        end
      end
      udrf_pkg::OP_TX_READY: begin
        if (tx_wr_ptr != tx_rd_ptr) begin
          r.line_valid = 1'b1;
          r.line_byte  = tx_ring[tx_rd_ptr];
          tx_rd_ptr = ring_inc(tx_rd_ptr, udrf_pkg::TX_DEPTH);
        end
      end
      udrf_pkg::OP_RX_BYTE: begin
        if (c.ovr) begin
          overruns = overruns + 8'd1;
          r.status = udrf_pkg::ST_OVERRUN;
        end else begin
          if (c.ferr) framings = framings + 8'd1;
          nxt = ring_inc(rx_wr_ptr, udrf_pkg::RX_DEPTH);
          if (nxt != rx_rd_ptr) begin
            rx_ring[rx_wr_ptr] = c.data;
            rx_wr_ptr = nxt;
          end else begin
            drops = drops + 8'd1;
            r.status = udrf_pkg::ST_RX_DROP;
          end
        end
      end
      default: begin
        if (rx_wr_ptr == rx_rd_ptr) begin
          r.status = udrf_pkg::ST_RX_EMPTY;
        end else begin
          r.read_valid = 1'b1;
          r.read_byte  = rx_ring[rx_rd_ptr];
          rx_rd_ptr = ring_inc(rx_rd_ptr, udrf_pkg::RX_DEPTH);
        end
      end
    endcase
    r.rx_available  = (rx_wr_ptr != rx_rd_ptr);
    r.tx_empty      = (tx_wr_ptr == tx_rd_ptr);
    r.tx_pending    = (tx_wr_ptr != tx_rd_ptr);
    r.overrun_count = overruns;
    r.framing_count = framings;
    r.drop_count    = drops;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %0d at %0t: %s", mismatch_count + 1, $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic queue_cmd(udrf_pkg::op_t op, udrf_pkg::byte_t data, logic hold_free,
                           logic ovr, logic ferr);
    uart_cmd_t c;
    c.op        = op;
    c.data      = data;
    c.hold_free = hold_free;
    c.ovr       = ovr;
    c.ferr      = ferr;
    pending_cmds.push_back(c);
  endtask

  // Hold until every queued command is sent and every result has come back
  task automatic wait_for_idle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_if.valid || expected_results.size() != 0);
  endtask

  // Drive one command per handshake, predicting at acceptance
  always @(posedge clk) begin
    uart_cmd_t         seen;
    uart_cmd_t         next_cmd;
    udrf_pkg::result_t want;
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        seen.op        = udrf_pkg::op_t'(cmd_if.op);
        seen.data      = cmd_if.data;
        seen.hold_free = cmd_if.tx_holding_empty;
        seen.ovr       = cmd_if.overrun;
        seen.ferr      = cmd_if.framing_error;
        want = step_rings(seen);
        expected_results.push_back(want);
        op_count[seen.op]++;
        if (want.status == udrf_pkg::ST_TX_FULL) tx_full_seen++;
        if (want.status == udrf_pkg::ST_RX_DROP) rx_drop_seen++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          cmd_if.valid            <= 1'b1;
          cmd_if.op               <= next_cmd.op;
          cmd_if.data             <= next_cmd.data;
          cmd_if.tx_holding_empty <= next_cmd.hold_free;
          cmd_if.overrun          <= next_cmd.ovr;
          cmd_if.framing_error    <= next_cmd.ferr;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Collect results and compare against the oldest prediction
  always @(posedge clk) begin
    udrf_pkg::result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("line_valid", res_if.line_valid, want.line_valid);
          check_field("line_byte", res_if.line_byte, want.line_byte);
          check_field("read_valid", res_if.read_valid, want.read_valid);
          check_field("read_byte", res_if.read_byte, want.read_byte);
          check_field("status", res_if.status, want.status);
          check_field("rx_available", res_if.rx_available, want.rx_available);
          check_field("tx_empty", res_if.tx_empty, want.tx_empty);
          check_field("tx_pending", res_if.tx_pending, want.tx_pending);
          check_field("overrun_count", res_if.overrun_count, want.overrun_count);
          check_field("framing_count", res_if.framing_count, want.framing_count);
          check_field("drop_count", res_if.drop_count, want.drop_count);
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which neither side moves a transaction
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= NO_PROGRESS_LIMIT);
    $display("watchdog: no transaction for %0d cycles", NO_PROGRESS_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Boundary cases on empty rings, direct send, flags and byte extremes
  task automatic add_directed();
    queue_cmd(udrf_pkg::OP_TX_READY,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_READ,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_WRITE, 8'hff, 1'b1, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_WRITE, 8'h00, 1'b0, 1'b1, 1'b1);
    queue_cmd(udrf_pkg::OP_CPU_WRITE, 8'h80, 1'b1, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_TX_READY,  8'hff, 1'b1, 1'b1, 1'b1);
    queue_cmd(udrf_pkg::OP_TX_READY,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_TX_READY,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_RX_BYTE,   8'hff, 1'b1, 1'b1, 1'b1);
    queue_cmd(udrf_pkg::OP_RX_BYTE,   8'h00, 1'b0, 1'b0, 1'b1);
    queue_cmd(udrf_pkg::OP_RX_BYTE,   8'h5a, 1'b0, 1'b1, 1'b0);
    queue_cmd(udrf_pkg::OP_RX_BYTE,   8'hff, 1'b1, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_READ,  8'hff, 1'b1, 1'b1, 1'b1);
    queue_cmd(udrf_pkg::OP_CPU_READ,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_READ,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_WRITE, 8'h01, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_CPU_WRITE, 8'h7f, 1'b1, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_TX_READY,  8'h00, 1'b0, 1'b0, 1'b0);
    queue_cmd(udrf_pkg::OP_TX_READY,  8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // Fill both rings past full, then wrap all three error counters on a full rx ring
  task automatic add_ring_extremes();
    for (int k = 0; k < udrf_pkg::TX_DEPTH; k++)
      queue_cmd(udrf_pkg::OP_CPU_WRITE, udrf_pkg::byte_t'($urandom_range(255)),
                1'b0, 1'b0, 1'b0);
    for (int k = 0; k < udrf_pkg::TX_DEPTH; k++)
      queue_cmd(udrf_pkg::OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
    for (int k = 0; k < udrf_pkg::RX_DEPTH - 1; k++)
      queue_cmd(udrf_pkg::OP_RX_BYTE, udrf_pkg::byte_t'($urandom_range(255)),
                1'b0, 1'b0, 1'b0);
    for (int k = 0; k < 260; k++) begin
      queue_cmd(udrf_pkg::OP_RX_BYTE, udrf_pkg::byte_t'($urandom_range(255)),
                1'b0, 1'b1, 1'($urandom_range(1)));
      queue_cmd(udrf_pkg::OP_RX_BYTE, udrf_pkg::byte_t'($urandom_range(255)),
                1'b0, 1'b0, 1'b1);
    end
    for (int k = 0; k < udrf_pkg::RX_DEPTH; k++)
      queue_cmd(udrf_pkg::OP_CPU_READ, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  // Bursts that push a ring toward full or empty, mixed with free noise
  task automatic add_random(int count);
    int        made;
    int        len;
    burst_t    mode;
    uart_cmd_t c;
    made = 0;
    while (made < count) begin
      mode = burst_t'($urandom_range(4));
      len  = $urandom_range(4, 24);
      for (int k = 0; k < len && made < count; k++) begin
        case ($urandom_range(15))
          0:       c.data = 8'h00;
          1:       c.data = 8'hff;
          default: c.data = udrf_pkg::byte_t'($urandom_range(255));
        endcase
        c.hold_free = 1'($urandom_range(1));
        c.ovr       = ($urandom_range(9) == 0);
        c.ferr      = ($urandom_range(6) == 0);
        case (mode)
          FILL_TX: begin
            c.op = ($urandom_range(99) < 85) ? udrf_pkg::OP_CPU_WRITE : udrf_pkg::OP_TX_READY;
            c.hold_free = ($urandom_range(99) < 15);
          end
          DRAIN_TX: c.op = ($urandom_range(99) < 85) ? udrf_pkg::OP_TX_READY
                                                     : udrf_pkg::OP_CPU_WRITE;
          FILL_RX:  c.op = ($urandom_range(99) < 85) ? udrf_pkg::OP_RX_BYTE
                                                     : udrf_pkg::OP_CPU_READ;
          DRAIN_RX: c.op = ($urandom_range(99) < 85) ? udrf_pkg::OP_CPU_READ
                                                     : udrf_pkg::OP_RX_BYTE;
          default: begin
            c.op   = udrf_pkg::op_t'($urandom_range(3));
            c.ovr  = 1'($urandom_range(1));
            c.ferr = 1'($urandom_range(1));
          end
        endcase
        pending_cmds.push_back(c);
        made++;
      end
    end
  endtask

  initial begin
    cmd_if.valid            = 1'b0;
    cmd_if.op               = udrf_pkg::OP_CPU_WRITE;
    cmd_if.data             = 8'h00;
    cmd_if.tx_holding_empty = 1'b0;
    cmd_if.overrun          = 1'b0;
    cmd_if.framing_error    = 1'b0;
    res_if.ready            = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Back-to-back traffic with no idling
    add_directed();
    add_ring_extremes();
    add_random(40);
    wait_for_idle();

    // Sender idles often
    send_idle_pct  = 60;
    recv_stall_pct = 0;
    add_random(36);
    wait_for_idle();

    // Receiver stalls often
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    add_random(36);
    wait_for_idle();

    // Both sides hold off
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    add_random(42);
    wait_for_idle();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d cpu writes, %0d tx ready, %0d line receives, %0d cpu reads",
             op_count[udrf_pkg::OP_CPU_WRITE], op_count[udrf_pkg::OP_TX_READY],
             op_count[udrf_pkg::OP_RX_BYTE], op_count[udrf_pkg::OP_CPU_READ]);
    $display("hit %0d tx full refusals, %0d rx drops, %0d field mismatches",
             tx_full_seen, rx_drop_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
